>>> hdl/rat_pkg.sv
// shared types and constants for the rational add / multiply / compare unit
`default_nettype none

package rat_pkg;

  // operand width, numerators and denominators
  localparam int FIELD_BITS = 16;

  // internal widths follow from the operand width
  localparam int PROD_W    = 2 * FIELD_BITS;
  localparam int SUM_W     = PROD_W + 1;
  localparam int SH_W      = $clog2(SUM_W + 1);
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // result field widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

  // operation codes
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_MUL  = 2'd1;
  localparam logic [1:0] KIND_CMP  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unused code, every result field reads zero

  // multiplier operand selection
  localparam logic [1:0] MSEL_NUM = 2'd0;  // an*bd (add) or an*bn (mul)
  localparam logic [1:0] MSEL_CRS = 2'd1;  // ad*bn
  localparam logic [1:0] MSEL_DEN = 2'd2;  // ad*bd

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sum_en;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       finish;
  } rat_cmd_t;

  typedef struct packed {
    logic arith;
    logic num_zero;
    logic gcd_done;
  } rat_sts_t;

endpackage

`default_nettype wire

>>> hdl/rat_ctrl.sv
// controller state machine sequencing the rational datapath
`default_nettype none

module rat_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done_o,
  input  wire rat_pkg::rat_sts_t sts_i,
  output rat_pkg::rat_cmd_t      cmd_o
);
  import rat_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_GINIT = 4'd4;
  localparam logic [3:0] ST_GCD   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign busy   = !((state_q == ST_IDLE) || (state_q == ST_DONE));
  assign done_o = (state_q == ST_DONE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (sts_i.arith) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_q[1:0];
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q[1:0] == MSEL_DEN) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ST_GINIT;
      end
      ST_GINIT: begin
        if (sts_i.num_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = ST_GCD;
        end
      end
      ST_GCD: begin
        cnt_d = '0;
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_DONE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> done_o)
    else $error("finish not followed by result strobe");

  a_gcd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gcd_step |-> !sts_i.gcd_done)
    else $error("gcd step issued after gcd finished");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
    else $error("divide step counter overran");

endmodule

`default_nettype wire

>>> hdl/rat_dpath.sv
// datapath: shared multiplier, binary gcd and twin restoring dividers
`default_nettype none

module rat_dpath (
  input  wire logic                               clk_i,
  input  wire rat_pkg::rat_cmd_t                  cmd_i,
  output rat_pkg::rat_sts_t                       sts_o,
  input  wire logic [1:0]                         kind_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0]     a_num_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0]     a_den_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0]     b_num_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0]     b_den_i,
  output logic [rat_pkg::NUM_W-1:0]               res_num_o,
  output logic [rat_pkg::DEN_W-1:0]               res_den_o,
  output logic                                    res_empty_o,
  output logic                                    is_equal_o
);
  import rat_pkg::*;

  logic [1:0]            kind_q;
  logic [FIELD_BITS-1:0] an_q, ad_q, bn_q, bd_q;
  logic [PROD_W-1:0]     p0_q, p1_q, den_q;
  logic [SUM_W-1:0]      num_q;
  logic [SUM_W-1:0]      gx_q, gy_q;
  logic [SH_W-1:0]       gk_q;
  logic [PROD_W-1:0]     g_q;
  logic [SUM_W-1:0]      qn_q, qd_q, rn_q, rd_q;
  logic [NUM_W-1:0]      res_num_q;
  logic [DEN_W-1:0]      res_den_q;
  logic                  res_empty_q, is_equal_q;

  logic                  empty, arith, is_add;
  logic [FIELD_BITS-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic                  g_ge;
  logic [SUM_W-1:0]      g_diff;
  logic [SUM_W-1:0]      trial_n, trial_d, g_ext;
  logic                  take_n, take_d;

  assign empty  = (ad_q == '0) || (bd_q == '0);
  assign is_add = (kind_q == KIND_ADD);
  assign arith  = ((kind_q == KIND_ADD) || (kind_q == KIND_MUL)) && !empty;

  assign sts_o.arith    = arith;
  assign sts_o.num_zero = (num_q == '0);
  assign sts_o.gcd_done = (gx_q == '0) || (gy_q == '0);

  // one multiplier, operands chosen per step
  always_comb begin
    case (cmd_i.mul_sel)
      MSEL_NUM: begin
        mul_a = an_q;
        mul_b = is_add ? bd_q : bn_q;
      end
      MSEL_CRS: begin
        mul_a = ad_q;
        mul_b = bn_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // binary gcd, odd-odd step subtracts and halves
  assign g_ge   = (gx_q >= gy_q);
  assign g_diff = g_ge ? (gx_q - gy_q) : (gy_q - gx_q);

  // restoring division of numerator and denominator by the gcd
  assign g_ext   = SUM_W'(g_q);
  assign trial_n = {rn_q[SUM_W-2:0], qn_q[SUM_W-1]};
  assign trial_d = {rd_q[SUM_W-2:0], qd_q[SUM_W-1]};
  assign take_n  = (trial_n >= g_ext);
  assign take_d  = (trial_d >= g_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      an_q   <= a_num_i;
      ad_q   <= a_den_i;
      bn_q   <= b_num_i;
      bd_q   <= b_den_i;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MSEL_NUM: p0_q  <= mul_p;
        MSEL_CRS: p1_q  <= mul_p;
        default:  den_q <= mul_p;
      endcase
    end
    if (cmd_i.sum_en) begin
      num_q <= SUM_W'(p0_q) + (is_add ? SUM_W'(p1_q) : '0);
    end
    if (cmd_i.gcd_init) begin
      gx_q <= num_q;
      gy_q <= SUM_W'(den_q);
      gk_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1;
        gy_q <= gy_q >> 1;
        gk_q <= gk_q + 1'b1;
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (g_ge) begin
        gx_q <= g_diff >> 1;
      end else begin
        gy_q <= g_diff >> 1;
      end
    end
    if (cmd_i.div_init) begin
      g_q  <= PROD_W'((gx_q | gy_q) << gk_q);
      qn_q <= num_q;
      qd_q <= SUM_W'(den_q);
      rn_q <= '0;
      rd_q <= '0;
    end else if (cmd_i.div_step) begin
      rn_q <= take_n ? (trial_n - g_ext) : trial_n;
      rd_q <= take_d ? (trial_d - g_ext) : trial_d;
      qn_q <= {qn_q[SUM_W-2:0], take_n};
      qd_q <= {qd_q[SUM_W-2:0], take_d};
    end
    if (cmd_i.finish) begin
      if (arith) begin
        res_empty_q <= 1'b0;
        is_equal_q  <= 1'b0;
        if (num_q == '0) begin
          res_num_q <= '0;
          res_den_q <= DEN_W'(den_q);
        end else begin
          res_num_q <= NUM_W'(qn_q);
          res_den_q <= DEN_W'(qd_q);
        end
      end else begin
        res_num_q   <= '0;
        res_den_q   <= '0;
        res_empty_q <= empty && (kind_q != KIND_NONE);
        is_equal_q  <= (kind_q == KIND_CMP) && !empty && (an_q == bn_q) && (ad_q == bd_q);
      end
    end
  end

  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign res_empty_o = res_empty_q;
  assign is_equal_o  = is_equal_q;

  a_div_nonzero: assert property (@(posedge clk_i)
    cmd_i.div_step |-> (g_q != '0))
    else $error("division by a zero gcd");

  a_den_nonzero: assert property (@(posedge clk_i)
    (cmd_i.finish && arith) |=> (res_den_o != '0))
    else $error("arithmetic result with zero denominator");

endmodule

`default_nettype wire

>>> hdl/rational_add_mul_reduce.sv
// top level of the rational add / multiply / compare unit
// timing: compare, empty operand and unused code go straight to done_o after the check;
//   a zero sum or product finishes after the sum, else the gcd loop and divider run;
//   the gcd loop (one shift or subtract per cycle) and the 33-step divider set the length
// throughput: one item at a time, next start taken in the cycle done_o is high
// reset: rst_ni low returns the controller to idle, busy low, no strobe;
//   results are strobed for one cycle and the receiver cannot stall
`default_nettype none

module rational_add_mul_reduce (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0] a_num_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0] a_den_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0] b_num_i,
  input  wire logic [rat_pkg::FIELD_BITS-1:0] b_den_i,
  output logic                                done_o,
  output logic [rat_pkg::NUM_W-1:0]           res_num_o,
  output logic [rat_pkg::DEN_W-1:0]           res_den_o,
  output logic                                res_empty_o,
  output logic                                is_equal_o
);
  import rat_pkg::*;

  // command and status between sequencer and datapath
  rat_cmd_t cmd;
  rat_sts_t sts;

  // sequencer: load, multiply steps, sum, gcd loop, divide loop, result beat
  rat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // datapath holds the operands and the registered result fields
  rat_dpath u_dpath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .a_num_i     (a_num_i),
    .a_den_i     (a_den_i),
    .b_num_i     (b_num_i),
    .b_den_i     (b_den_i),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .res_empty_o (res_empty_o),
    .is_equal_o  (is_equal_o)
  );

endmodule

`default_nettype wire
